// File: rtl/core/pef_pkg.sv
package pef_pkg;

    // Field and register widths
    localparam int SampleW  = 16;
    localparam int EnvW     = 16;
    localparam int HoldW    = 17;
    localparam int PeriodW  = 16;
    localparam int FactorW  = 12;
    localparam int GainW    = 12;
    localparam int MulBW    = 12;
    localparam int ProdW    = EnvW + MulBW;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 16;

    // Fixed-point shifts and output shaping
    localparam int DecayShift = 12;
    localparam int GainShift  = 8;
    localparam int ScaledW    = ProdW - GainShift;
    localparam int OutOffset  = 32767;
    localparam int OutClip    = 32767;
    localparam int SnapLimit  = 2;

    // Register reset values
    localparam logic [PeriodW-1:0] DecayPeriodRst = 16'd0;
    localparam logic [FactorW-1:0] DecayFactorRst = 12'd4000;
    localparam logic [GainW-1:0]   OutputGainRst  = 12'd256;

    // Register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_DECAY_PERIOD = 2'd0,
        CFG_DECAY_FACTOR = 2'd1,
        CFG_OUTPUT_GAIN  = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [PeriodW-1:0] decay_period;
        logic [FactorW-1:0] decay_factor;
        logic [GainW-1:0]   output_gain;
    } cfg_t;

    // Envelopes below the snap limit collapse to zero
    function automatic logic [EnvW-1:0] snap_env(input logic [EnvW-1:0] env);
        logic [EnvW-1:0] res;
        res = (env < EnvW'(SnapLimit)) ? '0 : env;
        return res;
    endfunction

endpackage

// File: rtl/core/pef_sample_if.sv
interface pef_sample_if import pef_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [SampleW-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// File: rtl/core/pef_env_if.sv
interface pef_env_if import pef_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [SampleW-1:0] envelope_out;

    modport source (output valid, output envelope_out, input ready);
    modport sink   (input valid, input envelope_out, output ready);
endinterface

// File: rtl/core/peak_envelope_follower.sv
// A sample transaction moves the sequencer to the scale step, via the decay step on a decay;
// the result register loads there once the output register is free. A new sample is taken
// only back in idle. The single shared 16x12 multiplier is used once for the decay step and
// once for output scaling. One waiting result does not block the next sample; a second result
// holds in the scale step, with the input not ready, until the output register frees.
// Reset (rst_n, async, active low): envelope, hold count and output clear, registers reset.
module peak_envelope_follower import pef_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    pef_sample_if.sink          samples,
    pef_env_if.source           envelope,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_wdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECAY,
        ST_SCALE
    } state_t;

    state_t                    state_reg;
    logic [EnvW-1:0]           env_reg;
    logic [HoldW-1:0]          hold_reg;
    logic                      out_valid_reg;
    logic signed [SampleW-1:0] out_data_reg;

    cfg_t              cfg;
    logic [MulBW-1:0]  mul_b;
    logic [ProdW-1:0]  prod;
    logic [EnvW-1:0]   mag;
    logic              rising;
    logic              counting;
    logic [HoldW-1:0]  hold_inc;
    logic              decay_due;
    logic              accept;
    logic              out_free;
    logic [ScaledW-1:0] scaled;
    logic [SampleW-1:0] result;

    pef_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Multiplier operand: decay factor in the decay step, gain otherwise
    assign mul_b = (state_reg == ST_DECAY) ? MulBW'(cfg.decay_factor)
                                           : MulBW'(cfg.output_gain);

    pef_mul u_mul (
        .a    (env_reg),
        .b    (mul_b),
        .prod (prod)
    );

    // Sample magnitude, peak detect and hold counter
    assign mag       = samples.sample[SampleW-1] ? (~samples.sample + 16'd1)
                                                 : samples.sample;
    assign rising    = mag > env_reg;
    assign counting  = !rising && (env_reg != '0);
    assign hold_inc  = hold_reg + 17'd1;
    assign decay_due = counting && (hold_inc > HoldW'(cfg.decay_period));

    assign accept         = samples.valid && samples.ready;
    assign samples.ready  = (state_reg == ST_IDLE);
    assign out_free       = !out_valid_reg || envelope.ready;

    // Output scaling: drop gain fraction, remove offset, clip above
    assign scaled = prod[ProdW-1:GainShift];
    assign result = (scaled > ScaledW'(OutClip + OutOffset)) ? SampleW'(OutClip)
                  : SampleW'(scaled - ScaledW'(OutOffset));

    // Sequencer and registered output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            env_reg       <= '0;
            hold_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            // Output valid: set by the scale step, cleared by an output transaction
            if (state_reg == ST_SCALE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (envelope.valid && envelope.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (rising)
                        begin
                            env_reg   <= snap_env(mag);
                            state_reg <= ST_SCALE;
                        end
                        else if (decay_due)
                        begin
                            hold_reg  <= '0;
                            state_reg <= ST_DECAY;
                        end
                        else
                        begin
                            if (counting)
                            begin
                                hold_reg <= hold_inc;
                            end
                            state_reg <= ST_SCALE;
                        end
                    end
                end
                ST_DECAY:
                begin
                    env_reg   <= snap_env(prod[DecayShift +: EnvW]);
                    state_reg <= ST_SCALE;
                end
                ST_SCALE:
                begin
                    if (out_free)
                    begin
                        out_data_reg  <= $signed(result);
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign envelope.valid        = out_valid_reg;
    assign envelope.envelope_out = out_data_reg;

endmodule

// File: rtl/core/pef_cfg.sv
module pef_cfg import pef_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_wdata,
    output cfg_t                cfg
);

    cfg_t cfg_reg;

    // Register file; writes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.decay_period <= DecayPeriodRst;
            cfg_reg.decay_factor <= DecayFactorRst;
            cfg_reg.output_gain  <= OutputGainRst;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_DECAY_PERIOD: cfg_reg.decay_period <= cfg_wdata[PeriodW-1:0];
                CFG_DECAY_FACTOR: cfg_reg.decay_factor <= cfg_wdata[FactorW-1:0];
                CFG_OUTPUT_GAIN:  cfg_reg.output_gain  <= cfg_wdata[GainW-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/core/pef_mul.sv
module pef_mul import pef_pkg::*;
(
    input  logic [EnvW-1:0]  a,
    input  logic [MulBW-1:0] b,
    output logic [ProdW-1:0] prod
);

    // Shared unsigned multiplier: decay step and output scaling
    assign prod = ProdW'(a) * ProdW'(b);

endmodule

// File: rtl/core/pef_chk.sv
module pef_chk import pef_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic signed [SampleW-1:0] out_data
);

    // A sample transaction starts the sequencer, which stops taking samples
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready while a sample is in work");

    // A new result only appears at the end of sample work
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without sample work");

    // Offset output never reaches the most negative code
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data != 16'sh8000)
        else $error("result below -32767");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

endmodule

bind peak_envelope_follower pef_chk u_pef_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (envelope.valid),
    .out_ready (envelope.ready),
    .out_data  (envelope.envelope_out)
);

// File: tb/peak_envelope_follower_test.sv
`timescale 1ns / 1ps

module peak_envelope_follower_test;
    import pef_pkg::*;

    localparam int MaxReports  = 10;
    localparam int SettleTicks = 4;      // quiet margin before a register write
    localparam int DrainLimit  = 20000;
    localparam int PhaseItems  = 150;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t    kind;
        cfg_idx_t     reg_idx;
        logic [15:0]  value;
        bit           pinned;
        logic [15:0]  want;
    } dir_row_t;

    // Directed rows; pinned results are read straight off the behavior,
    // the rest come from the envelope predictor.
    localparam int DirRows = 29;
    dir_row_t dir_rows [DirRows] = '{
        // reset settings: period 0, factor 4000, gain 256
        '{ROW_SAMPLE, CFG_DECAY_PERIOD, 16'h0000, 1'b1, 16'h8001},
        '{ROW_SAMPLE, CFG_DECAY_PERIOD, 16'h7FFF, 1'b1, 16'h0000},
        '{ROW_SAMPLE, CFG_DECAY_PERIOD, 16'h8000, 1'b1, 16'h0001},
        '{ROW_SAMPLE, CFG_DECAY_PERIOD, 16'h0000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, CFG_DECAY_PERIOD, 16'h0001, 1'b0, 16'h0000},
        '{ROW_SAMPLE, CFG_DECAY_PERIOD, 16'hFFFF, 1'b0, 16'h0000},
        '{ROW_SAMPLE, CFG_DECAY_PERIOD, 16'h7FFF, 1'b0, 16'h0000},
        // zero decay factor wipes the held peak
        '{ROW_WRITE,  CFG_DECAY_FACTOR, 16'h0000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, CFG_DECAY_PERIOD, 16'h03E8, 1'b1, 16'h8001},
        '{ROW_SAMPLE, CFG_DECAY_PERIOD, 16'h03E8, 1'b1, 16'h83E9},
        '{ROW_SAMPLE, CFG_DECAY_PERIOD, 16'h0000, 1'b1, 16'h8001},
        // top settings: output clips, long hold keeps the peak
        '{ROW_WRITE,  CFG_DECAY_FACTOR, 16'h0FFF, 1'b0, 16'h0000},
        '{ROW_WRITE,  CFG_OUTPUT_GAIN,  16'h0FFF, 1'b0, 16'h0000},
        '{ROW_WRITE,  CFG_DECAY_PERIOD, 16'hFFFF, 1'b0, 16'h0000},
        '{ROW_SAMPLE, CFG_DECAY_PERIOD, 16'h8000, 1'b1, 16'h7FFF},
        '{ROW_SAMPLE, CFG_DECAY_PERIOD, 16'h0000, 1'b1, 16'h7FFF},
        '{ROW_SAMPLE, CFG_DECAY_PERIOD, 16'h0000, 1'b1, 16'h7FFF},
        '{ROW_SAMPLE, CFG_DECAY_PERIOD, 16'h4000, 1'b1, 16'h7FFF},
        // zero gain gives the bottom of the range
        '{ROW_WRITE,  CFG_OUTPUT_GAIN,  16'h0000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, CFG_DECAY_PERIOD, 16'h0000, 1'b1, 16'h8001},
        '{ROW_WRITE,  CFG_DECAY_FACTOR, 16'h0000, 1'b0, 16'h0000},
        '{ROW_WRITE,  CFG_DECAY_PERIOD, 16'h0000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, CFG_DECAY_PERIOD, 16'h0000, 1'b1, 16'h8001},
        // small envelopes snap to zero after a half-factor decay
        '{ROW_WRITE,  CFG_OUTPUT_GAIN,  16'h0100, 1'b0, 16'h0000},
        '{ROW_WRITE,  CFG_DECAY_FACTOR, 16'h0800, 1'b0, 16'h0000},
        '{ROW_SAMPLE, CFG_DECAY_PERIOD, 16'h0003, 1'b1, 16'h8004},
        '{ROW_SAMPLE, CFG_DECAY_PERIOD, 16'h0000, 1'b1, 16'h8001},
        '{ROW_SAMPLE, CFG_DECAY_PERIOD, 16'hFFFE, 1'b0, 16'h0000},
        '{ROW_SAMPLE, CFG_DECAY_PERIOD, 16'h0000, 1'b1, 16'h8001}
    };

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_wdata;

    pef_sample_if samples_if ();
    pef_env_if    env_if ();

    // Envelope predictor state and its copy of the registers
    logic [EnvW-1:0]    env_model;
    logic [HoldW-1:0]   hold_model;
    logic [PeriodW-1:0] period_model;
    logic [FactorW-1:0] factor_model;
    logic [GainW-1:0]   gain_model;

    logic [15:0] expected_env_q [$];

    int send_idle_pct;
    int recv_stall_pct;
    int sample_count;
    int result_count;
    int write_count;
    int mismatch_count;

    peak_envelope_follower i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples_if),
        .envelope  (env_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    // Receiver stalls
    always @(negedge clk)
    begin
        env_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Advance the envelope by one sample and return the scaled output
    function automatic logic [15:0] follow_sample(input logic [15:0] raw);
        logic [16:0] mag;
        logic        rising;
        logic [27:0] prod;
        int          scaled;
        mag    = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
        rising = 1'b0;
        if (mag > {1'b0, env_model})
        begin
            env_model = mag[15:0];
            rising    = 1'b1;
        end
        if (env_model != '0 && !rising)
        begin
            hold_model = hold_model + 17'd1;
            if (hold_model > {1'b0, period_model})
            begin
                hold_model = '0;
                prod       = 28'(env_model) * 28'(factor_model);
                env_model  = 16'(prod >> DecayShift);
            end
        end
        if (env_model < 16'(SnapLimit))
            env_model = '0;
        prod   = 28'(env_model) * 28'(gain_model);
        scaled = int'(prod >> GainShift) - OutOffset;
        if (scaled > OutClip)
            scaled = OutClip;
        return scaled[15:0];
    endfunction

    function automatic logic [15:0] quiet_sample();
        int m;
        m = $urandom_range(0, 64);
        return ($urandom_range(1) == 1) ? 16'(-m) : 16'(m);
    endfunction

    // Drop valid at the next falling edge
    task automatic release_samples();
        @(negedge clk);
        samples_if.valid <= 1'b0;
    endtask

    // Sender pauses until every expected result is back, then lets the block settle
    task automatic wait_idle();
        release_samples();
        while (expected_env_q.size() != 0)
            @(posedge clk);
        repeat (SettleTicks) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] val);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DECAY_PERIOD: period_model = val;
            CFG_DECAY_FACTOR: factor_model = val[FactorW-1:0];
            CFG_OUTPUT_GAIN:  gain_model   = val[GainW-1:0];
            default:          ;
        endcase
        write_count++;
    endtask

    // One sample transaction; the expectation is queued at acceptance
    task automatic send_sample(input logic [15:0] s, input bit pinned,
                               input logic [15:0] want);
        logic [15:0] predicted;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            samples_if.valid <= 1'b0;
            @(negedge clk);
        end
        samples_if.valid  <= 1'b1;
        samples_if.sample <= s;
        @(posedge clk);
        while (!samples_if.ready)
            @(posedge clk);
        predicted = follow_sample(s);
        expected_env_q.push_back(pinned ? want : predicted);
        sample_count++;
    endtask

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MaxReports)
            $display("%t: %s", $realtime, what);
    endtask

    // Random phase: random register settings, then peaks followed by quiet runs, plus noise and extremes
    task automatic run_phase(input int n_items, input int idle_pct, input int stall_pct);
        int          sent;
        int          pick;
        int          quiet_len;
        bit          paused;
        logic [15:0] v;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;

        pick = $urandom_range(99);
        if (pick < 65)
            v = 16'($urandom_range(0, 6));
        else if (pick < 85)
            v = 16'($urandom_range(7, 300));
        else if (pick < 95)
            v = 16'($urandom);
        else
            v = 16'hFFFF;
        write_reg(CFG_DECAY_PERIOD, v);

        pick = $urandom_range(99);
        if (pick < 10)
            v = 16'h0000;
        else if (pick < 20)
            v = 16'h0FFF;
        else if (pick < 70)
            v = 16'($urandom_range(3000, 4095));
        else
            v = 16'($urandom_range(0, 4095));
        write_reg(CFG_DECAY_FACTOR, v);

        pick = $urandom_range(99);
        if (pick < 15)
            v = 16'h0FFF;
        else if (pick < 25)
            v = 16'h0000;
        else
            v = 16'($urandom_range(0, 4095));
        write_reg(CFG_OUTPUT_GAIN, v);

        sent   = 0;
        paused = 1'b0;
        while (sent < n_items)
        begin
            if (!paused && sent >= n_items / 2)
            begin
                wait_idle();
                paused = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 15)
            begin
                send_sample(16'($urandom), 1'b0, '0);
                sent++;
            end
            else if (pick < 25)
            begin
                case ($urandom_range(4))
                    0:       v = 16'h8000;
                    1:       v = 16'h7FFF;
                    2:       v = 16'h0000;
                    3:       v = 16'h0001;
                    default: v = 16'hFFFF;
                endcase
                send_sample(v, 1'b0, '0);
                sent++;
            end
            else
            begin
                send_sample(16'($urandom), 1'b0, '0);
                sent++;
                quiet_len = $urandom_range(1, 24);
                while (quiet_len > 0 && sent < n_items)
                begin
                    send_sample(quiet_sample(), 1'b0, '0);
                    sent++;
                    quiet_len--;
                end
            end
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin : check_results
        logic [15:0] want;
        if (rst_n && env_if.valid && env_if.ready)
        begin
            result_count++;
            if (expected_env_q.size() == 0)
                note_mismatch($sformatf("unexpected result %0d",
                                        $signed(env_if.envelope_out)));
            else
            begin
                want = expected_env_q.pop_front();
                if (env_if.envelope_out !== want)
                    note_mismatch($sformatf("result %0d: expected %0d, got %0d",
                                            result_count, $signed(want),
                                            $signed(env_if.envelope_out)));
            end
        end
    end

    // Main sequence
    initial
    begin
        int drain;
        clk               = 1'b0;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_wdata         = '0;
        samples_if.valid  = 1'b0;
        samples_if.sample = '0;
        env_if.ready      = 1'b0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        sample_count      = 0;
        result_count      = 0;
        write_count       = 0;
        mismatch_count    = 0;
        env_model         = '0;
        hold_model        = '0;
        period_model      = DecayPeriodRst;
        factor_model      = DecayFactorRst;
        gain_model        = OutputGainRst;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part
        for (int i = 0; i < DirRows; i++)
        begin
            if (dir_rows[i].kind == ROW_WRITE)
                write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
            else
                send_sample(dir_rows[i].value, dir_rows[i].pinned, dir_rows[i].want);
        end

        // Random part across handshake pressure settings
        run_phase(PhaseItems, 0, 0);
        run_phase(PhaseItems, 82, 0);
        run_phase(PhaseItems, 0, 82);
        run_phase(PhaseItems, 35, 35);

        // Drain
        release_samples();
        drain = 0;
        while (expected_env_q.size() != 0 && drain < DrainLimit)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (SettleTicks) @(posedge clk);
        if (expected_env_q.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", expected_env_q.size()));

        $display("Sent %0d samples, checked %0d envelope results, %0d register writes,",
                 sample_count, result_count, write_count);
        $display("under four idle/stall mixes; %0d mismatches", mismatch_count);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/core/pef_pkg.sv
rtl/core/pef_sample_if.sv
rtl/core/pef_env_if.sv
rtl/core/pef_cfg.sv
rtl/core/pef_mul.sv
rtl/core/peak_envelope_follower.sv
rtl/core/pef_chk.sv
tb/peak_envelope_follower_test.sv
